### rtl/core/sensor_running_average_alert_core_defines.svh
// Assertion macros shared by the sensor running average alert core.
`ifndef SENSOR_RUNNING_AVERAGE_ALERT_CORE_DEFINES_SVH
`define SENSOR_RUNNING_AVERAGE_ALERT_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SRAA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sraa assertion failed");

// A condition that must hold in the cycle after a trigger.
`define SRAA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sraa assertion failed");

`endif

### rtl/core/sraa_pkg.sv
// Package with sizes, codes and types of the sensor running average alert core.
`default_nettype none
package sraa_pkg;
    localparam int MAX_SENSORS = 64;
    localparam int MAP_DEPTH = 64;
    localparam int STAT_IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int STAT_CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int MAP_IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int MAP_CNT_W = $clog2(MAP_DEPTH + 1);
    localparam int SUM_W = 48;
    localparam int COUNT_W = 32;
    localparam int ENTRY_W = SUM_W + COUNT_W + 2;
    localparam int DIV_STEP_W = $clog2(SUM_W);

    localparam logic [15:0] COLD_RESET = 16'd3840;
    localparam logic [15:0] HOT_RESET = 16'd7168;

    typedef enum logic [0:0] {
        REG_COLD = 1'b0,
        REG_HOT  = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        REQ_READING = 1'b0,
        REQ_MAP     = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_STAT_FULL = 3'd2,
        ST_MAP_OK   = 3'd3,
        ST_MAP_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_COLD   = 2'd1,
        CLS_HOT    = 2'd2
    } level_t;
endpackage
`default_nettype wire

### rtl/core/sraa_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module sraa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/sensor_running_average_alert_core.sv
// Top level of the sensor running average alert core.
// One item is handled at a time. The statistics table and the room map are
// searched one entry per cycle through their RAM read ports, and the average
// comes from a 48-step restoring divider. A finished result sits in the output
// register until it is taken; the next item is accepted once that result has
// been loaded. Thresholds may be written only while the block is idle.
`default_nettype none
`include "sensor_running_average_alert_core_defines.svh"
module sensor_running_average_alert_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [15:0] node_id,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [15:0] room_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      echo_sensor,
    output logic signed [15:0] average,
    output logic [31:0]      reading_total,
    output logic [1:0]       level_class,
    output logic             class_changed,
    output logic             room_found,
    output logic [15:0]      room_out
);
    localparam int IW = sraa_pkg::STAT_IDX_W;
    localparam int CW = sraa_pkg::STAT_CNT_W;
    localparam int MIW = sraa_pkg::MAP_IDX_W;
    localparam int MCW = sraa_pkg::MAP_CNT_W;
    localparam int SW = sraa_pkg::SUM_W;
    localparam int NW = sraa_pkg::COUNT_W;
    localparam int EW = sraa_pkg::ENTRY_W;
    localparam int DW = sraa_pkg::DIV_STEP_W;
    localparam int CMAX = (CW > MCW) ? CW : MCW;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SRCH, S_LOAD_RD, S_LOAD, S_ACC, S_ABS, S_DIV,
        S_SIGN, S_CLASS, S_MSRCH, S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] cold_reg, hot_reg;
    logic [CW-1:0] stat_used_reg;
    logic [MCW-1:0] map_used_reg;
    logic        req_reg;
    logic [15:0] id_reg;
    logic signed [15:0] sample_reg;
    logic [15:0] room_in_reg;
    logic [CMAX-1:0] idx_reg;
    logic        pend_reg;
    logic [IW-1:0] slot_reg;
    logic signed [SW-1:0] sum_reg;
    logic [NW-1:0] count_reg;
    logic [1:0]  cls_old_reg;
    logic        neg_reg;
    logic [SW-1:0] dvd_reg;
    logic [NW:0] rem_reg;
    logic [DW-1:0] step_reg;
    logic signed [15:0] avg_reg;
    logic [1:0]  cls_reg;
    logic [2:0]  status_work_reg;
    logic        found_reg;
    logic [15:0] room_reg;
    logic        out_valid_reg;

    logic          tag_we;
    logic [IW-1:0] tag_raddr;
    logic [15:0]   tag_rdata;
    logic          ent_we;
    logic [EW-1:0] ent_wdata;
    logic [EW-1:0] ent_rdata;
    logic          map_we;
    logic [MIW-1:0] map_raddr;
    logic [31:0]   map_rdata;

    logic srch_hit, srch_end, msrch_hit, msrch_end;
    logic [NW:0] rem_sh;
    logic [1:0]  cls_new;
    logic        out_load;

    sraa_ram #(.WIDTH(16), .DEPTH(sraa_pkg::MAX_SENSORS)) u_tag_ram (
        .clk(clk), .we(tag_we), .waddr(stat_used_reg[IW-1:0]), .wdata(id_reg),
        .raddr(tag_raddr), .rdata(tag_rdata)
    );

    sraa_ram #(.WIDTH(EW), .DEPTH(sraa_pkg::MAX_SENSORS)) u_entry_ram (
        .clk(clk), .we(ent_we), .waddr(slot_reg), .wdata(ent_wdata),
        .raddr(slot_reg), .rdata(ent_rdata)
    );

    sraa_ram #(.WIDTH(32), .DEPTH(sraa_pkg::MAP_DEPTH)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_used_reg[MIW-1:0]),
        .wdata({id_reg, room_in_reg}), .raddr(map_raddr), .rdata(map_rdata)
    );

    always_comb
    begin
        tag_raddr = idx_reg[IW-1:0];
        map_raddr = idx_reg[MIW-1:0];
        srch_hit = (state_reg == S_SRCH) && pend_reg && (tag_rdata == id_reg);
        srch_end = (state_reg == S_SRCH) && !pend_reg
                   && (idx_reg >= CMAX'(stat_used_reg));
        tag_we = srch_end && (stat_used_reg < CW'(sraa_pkg::MAX_SENSORS));
        msrch_hit = (state_reg == S_MSRCH) && pend_reg
                    && (map_rdata[31:16] == id_reg);
        msrch_end = (state_reg == S_MSRCH) && !pend_reg
                    && (idx_reg >= CMAX'(map_used_reg));
        map_we = (state_reg == S_DISPATCH) && (req_reg == sraa_pkg::REQ_MAP)
                 && (map_used_reg < MCW'(sraa_pkg::MAP_DEPTH));
        rem_sh = {rem_reg[NW-1:0], dvd_reg[SW-1]};
        if ($signed(avg_reg) < $signed(cold_reg))
        begin
            cls_new = sraa_pkg::CLS_COLD;
        end
        else if ($signed(avg_reg) > $signed(hot_reg))
        begin
            cls_new = sraa_pkg::CLS_HOT;
        end
        else
        begin
            cls_new = sraa_pkg::CLS_NORMAL;
        end
        ent_we = (state_reg == S_CLASS);
        ent_wdata = {sum_reg, count_reg, cls_new};
        out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        in_ready = (state_reg == S_IDLE);
        out_valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cold_reg <= sraa_pkg::COLD_RESET;
            hot_reg <= sraa_pkg::HOT_RESET;
            stat_used_reg <= '0;
            map_used_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sraa_pkg::REG_COLD: cold_reg <= cfg_data;
                    sraa_pkg::REG_HOT:  hot_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_type;
                        id_reg <= node_id;
                        sample_reg <= sample_value;
                        room_in_reg <= room_number;
                        avg_reg <= '0;
                        count_reg <= '0;
                        cls_reg <= sraa_pkg::CLS_NORMAL;
                        cls_old_reg <= sraa_pkg::CLS_NORMAL;
                        found_reg <= 1'b0;
                        room_reg <= '0;
                        idx_reg <= '0;
                        pend_reg <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (req_reg == sraa_pkg::REQ_MAP)
                    begin
                        if (map_we)
                        begin
                            map_used_reg <= map_used_reg + MCW'(1);
                            status_work_reg <= sraa_pkg::ST_MAP_OK;
                        end
                        else
                        begin
                            status_work_reg <= sraa_pkg::ST_MAP_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (id_reg == 16'd0)
                    begin
                        status_work_reg <= sraa_pkg::ST_INVALID;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        status_work_reg <= sraa_pkg::ST_OK;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (srch_hit)
                    begin
                        slot_reg <= IW'(idx_reg - CMAX'(1));
                        pend_reg <= 1'b0;
                        state_reg <= S_LOAD_RD;
                    end
                    else if (srch_end)
                    begin
                        if (tag_we)
                        begin
                            slot_reg <= stat_used_reg[IW-1:0];
                            stat_used_reg <= stat_used_reg + CW'(1);
                            sum_reg <= '0;
                            count_reg <= '0;
                            cls_old_reg <= sraa_pkg::CLS_NORMAL;
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            status_work_reg <= sraa_pkg::ST_STAT_FULL;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (idx_reg < CMAX'(stat_used_reg))
                    begin
                        pend_reg <= 1'b1;
                        idx_reg <= idx_reg + CMAX'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                S_LOAD_RD:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    sum_reg <= ent_rdata[EW-1 -: SW];
                    count_reg <= ent_rdata[NW+1:2];
                    cls_old_reg <= ent_rdata[1:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (count_reg != '1)
                    begin
                        sum_reg <= sum_reg + SW'(sample_reg);
                        count_reg <= count_reg + NW'(1);
                    end
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    neg_reg <= sum_reg[SW-1];
                    dvd_reg <= sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
                    rem_reg <= '0;
                    step_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, count_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, count_reg};
                        dvd_reg <= {dvd_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + DW'(1);
                    if (step_reg == DW'(SW - 1))
                    begin
                        state_reg <= S_SIGN;
                    end
                end
                S_SIGN:
                begin
                    avg_reg <= neg_reg ? 16'(-dvd_reg[15:0]) : dvd_reg[15:0];
                    state_reg <= S_CLASS;
                end
                S_CLASS:
                begin
                    cls_reg <= cls_new;
                    idx_reg <= '0;
                    pend_reg <= 1'b0;
                    state_reg <= S_MSRCH;
                end
                S_MSRCH:
                begin
                    if (msrch_hit)
                    begin
                        found_reg <= 1'b1;
                        room_reg <= map_rdata[15:0];
                        pend_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (msrch_end)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg < CMAX'(map_used_reg))
                    begin
                        pend_reg <= 1'b1;
                        idx_reg <= idx_reg + CMAX'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        status <= status_work_reg;
                        echo_sensor <= id_reg;
                        if (status_work_reg == sraa_pkg::ST_OK)
                        begin
                            average <= avg_reg;
                            reading_total <= count_reg;
                            level_class <= cls_reg;
                            class_changed <= (cls_reg != cls_old_reg);
                            room_found <= found_reg;
                            room_out <= room_reg;
                        end
                        else
                        begin
                            average <= '0;
                            reading_total <= '0;
                            level_class <= sraa_pkg::CLS_NORMAL;
                            class_changed <= 1'b0;
                            room_found <= 1'b0;
                            room_out <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SRAA_ASSERT_ALWAYS(a_stat_used_bound, stat_used_reg <= CW'(sraa_pkg::MAX_SENSORS))
    `SRAA_ASSERT_ALWAYS(a_map_used_bound, map_used_reg <= MCW'(sraa_pkg::MAP_DEPTH))
    `SRAA_ASSERT_ALWAYS(a_div_nonzero, (state_reg != S_DIV) || (count_reg != '0))
    `SRAA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire

### tb/tb_sensor_running_average_alert_core.sv
// Self-checking testbench for the sensor running average alert core.
`timescale 1ns / 100ps
`default_nettype none

class avg_alert_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sensor;
        logic [15:0] average;
        logic [31:0] total;
        logic [1:0]  level;
        logic        changed;
        logic        found;
        logic [15:0] room;
    } alert_result_t;

    alert_result_t expected_results[$];
    logic signed [15:0] cold_limit;
    logic signed [15:0] hot_limit;
    logic [15:0] sensor_tags[sraa_pkg::MAX_SENSORS];
    longint sensor_sums[sraa_pkg::MAX_SENSORS];
    logic [31:0] sensor_counts[sraa_pkg::MAX_SENSORS];
    logic [1:0] sensor_levels[sraa_pkg::MAX_SENSORS];
    int sensors_used;
    logic [15:0] room_sensors[sraa_pkg::MAP_DEPTH];
    logic [15:0] room_values[sraa_pkg::MAP_DEPTH];
    int rooms_used;
    int mismatches;

    function new();
        cold_limit = sraa_pkg::COLD_RESET;
        hot_limit = sraa_pkg::HOT_RESET;
        sensors_used = 0;
        rooms_used = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void set_threshold(sraa_pkg::reg_index_t idx, logic [15:0] value);
        if (idx == sraa_pkg::REG_COLD)
            cold_limit = value;
        else
            hot_limit = value;
    endfunction

    function void note_input(logic req, logic [15:0] id, logic signed [15:0] sample,
                             logic [15:0] room);
        alert_result_t r;
        int slot;
        longint quotient;
        r = '0;
        r.sensor = id;
        slot = -1;
        if (req == sraa_pkg::REQ_MAP) begin
            if (rooms_used < sraa_pkg::MAP_DEPTH) begin
                room_sensors[rooms_used] = id;
                room_values[rooms_used] = room;
                rooms_used++;
                r.status = sraa_pkg::ST_MAP_OK;
            end
            else
                r.status = sraa_pkg::ST_MAP_FULL;
        end
        else if (id == 16'd0)
            r.status = sraa_pkg::ST_INVALID;
        else begin
            for (int i = 0; i < sensors_used; i++)
                if (slot < 0 && sensor_tags[i] == id)
                    slot = i;
            if (slot < 0 && sensors_used < sraa_pkg::MAX_SENSORS) begin
                slot = sensors_used;
                sensor_tags[slot] = id;
                sensor_sums[slot] = 0;
                sensor_counts[slot] = 0;
                sensor_levels[slot] = sraa_pkg::CLS_NORMAL;
                sensors_used++;
            end
            if (slot < 0)
                r.status = sraa_pkg::ST_STAT_FULL;
            else begin
                if (sensor_counts[slot] != 32'hFFFF_FFFF) begin
                    sensor_sums[slot] += longint'(sample);
                    sensor_counts[slot]++;
                end
                quotient = sensor_sums[slot] / longint'({32'd0, sensor_counts[slot]});
                r.status = sraa_pkg::ST_OK;
                r.average = quotient[15:0];
                r.total = sensor_counts[slot];
                if (quotient < longint'(cold_limit))
                    r.level = sraa_pkg::CLS_COLD;
                else if (quotient > longint'(hot_limit))
                    r.level = sraa_pkg::CLS_HOT;
                else
                    r.level = sraa_pkg::CLS_NORMAL;
                r.changed = (r.level != sensor_levels[slot]);
                sensor_levels[slot] = r.level;
                for (int i = 0; i < rooms_used; i++)
                    if (!r.found && room_sensors[i] == id) begin
                        r.found = 1'b1;
                        r.room = room_values[i];
                    end
            end
        end
        expected_results.push_back(r);
    endfunction

    function void check_result(alert_result_t actual);
        alert_result_t exp_r;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result transfer: %p", actual);
            return;
        end
        exp_r = expected_results.pop_front();
        if (exp_r.status !== actual.status || exp_r.sensor !== actual.sensor ||
            exp_r.average !== actual.average || exp_r.total !== actual.total ||
            exp_r.level !== actual.level || exp_r.changed !== actual.changed ||
            exp_r.found !== actual.found || exp_r.room !== actual.room) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch at %0t: expected %p, actual %p", $time, exp_r, actual);
        end
    endfunction
endclass

module tb_sensor_running_average_alert_core;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [15:0] node_id;
    logic signed [15:0] sample_value;
    logic [15:0] room_number;
    logic out_valid;
    logic out_ready;
    logic [2:0] status;
    logic [15:0] echo_sensor;
    logic signed [15:0] average;
    logic [31:0] reading_total;
    logic [1:0] level_class;
    logic class_changed;
    logic room_found;
    logic [15:0] room_out;

    avg_alert_scoreboard alerts = new();
    int ready_stall_pct;
    int idle_cycles;
    logic [15:0] id_pool[8];

    sensor_running_average_alert_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .node_id(node_id),
        .sample_value(sample_value), .room_number(room_number),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .echo_sensor(echo_sensor), .average(average),
        .reading_total(reading_total), .level_class(level_class),
        .class_changed(class_changed), .room_found(room_found), .room_out(room_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            alerts.note_input(req_type, node_id, sample_value, room_number);
        if (rst_n && out_valid && out_ready)
            alerts.check_result({status, echo_sensor, average, reading_total,
                                 level_class, class_changed, room_found, room_out});
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(logic req, logic [15:0] id, logic [15:0] sample,
                             logic [15:0] room, int gap);
        in_valid <= 1'b1;
        req_type <= req;
        node_id <= id;
        sample_value <= sample;
        room_number <= room;
        do
            @(posedge clk);
        while (!in_ready);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_threshold(sraa_pkg::reg_index_t idx, logic [15:0] value);
        while (alerts.pending() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        alerts.set_threshold(idx, value);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, int id_span);
        int burst;
        int gap;
        int pick;
        logic [15:0] id;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
            burst--;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                id = 16'd0;
            else if (pick < 15)
                id = 16'($urandom);
            else if (pick < 60)
                id = id_pool[$urandom_range(0, 7)];
            else
                id = 16'($urandom_range(1, id_span));
            send_item($urandom_range(0, 99) < 15 ? sraa_pkg::REQ_MAP : sraa_pkg::REQ_READING,
                      id, 16'($urandom), 16'($urandom), burst == 0 ? gap : 0);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sraa_pkg::REG_COLD;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        req_type = sraa_pkg::REQ_READING;
        node_id = 16'd0;
        sample_value = 16'sd0;
        room_number = 16'd0;
        out_ready = 1'b0;
        ready_stall_pct = 0;
        idle_cycles = 0;
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom_range(1, 65535));
        id_pool[0] = 16'hFFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid id, map id zero, duplicate map, extreme samples.
        send_item(sraa_pkg::REQ_READING, 16'd0, 16'h1234, 16'd5, 0);
        send_item(sraa_pkg::REQ_MAP, 16'd0, 16'd0, 16'hFFFF, 0);
        send_item(sraa_pkg::REQ_MAP, 16'hFFFF, 16'h7FFF, 16'd77, 1);
        send_item(sraa_pkg::REQ_MAP, 16'hFFFF, 16'd0, 16'd88, 0);
        send_item(sraa_pkg::REQ_READING, 16'hFFFF, 16'h7FFF, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'hFFFF, 16'h8000, 16'd0, 2);
        send_item(sraa_pkg::REQ_READING, 16'd1, 16'h8000, 16'hFFFF, 0);
        send_item(sraa_pkg::REQ_READING, 16'd1, 16'h8000, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'd2, 16'h1C01, 16'd0, 3);
        send_item(sraa_pkg::REQ_READING, 16'd3, 16'h0F00, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'd4, 16'h1C00, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'd5, 16'hFFFF, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'd5, 16'h0000, 16'd0, 0);
        send_item(sraa_pkg::REQ_READING, 16'd5, 16'h0001, 16'd0, 0);
        in_valid <= 1'b0;

        write_threshold(sraa_pkg::REG_COLD, 16'h8000);
        write_threshold(sraa_pkg::REG_HOT, 16'h7FFF);
        ready_stall_pct = 30;
        run_random(200, 40);

        write_threshold(sraa_pkg::REG_COLD, 16'h7FFF);
        write_threshold(sraa_pkg::REG_HOT, 16'h8000);
        ready_stall_pct = 0;
        run_random(120, 60);

        write_threshold(sraa_pkg::REG_COLD, 16'($urandom_range(0, 65535)) | 16'h8000);
        write_threshold(sraa_pkg::REG_HOT, 16'($urandom_range(0, 32767)));
        ready_stall_pct = 70;
        run_random(240, 200);

        write_threshold(sraa_pkg::REG_COLD, 16'd3840);
        write_threshold(sraa_pkg::REG_HOT, 16'd7168);
        ready_stall_pct = 20;
        run_random(240, 65535);

        while (alerts.pending() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (alerts.mismatches == 0 && alerts.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
